// ----- sv/joystick_rate_slew_limiter_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the joystick rate slew limiter
// Immediate-style wrappers around concurrent checks clocked on clk and
// disabled during reset. They compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_RATE_SLEW_LIMITER_TOP_MACROS_SVH
`define JOYSTICK_RATE_SLEW_LIMITER_TOP_MACROS_SVH

`ifndef SYNTH
// Antecedent and consequent in the same cycle.
`define JRSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define JRSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JRSL_ASSERT_IMP(lbl, ante, cons, msg)
`define JRSL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/jrsl_pkg.sv -----
// ----------------------------------------------------------------------------
// jrsl_pkg
// Types and constants shared by the joystick rate slew limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jrsl_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ERR_W   = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 12;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SCALE_MODE = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_CENTER     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_OUT_MIN    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_OUT_MAX    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_DEAD_LOW   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_DEAD_HIGH  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_SLOW_WIDTH = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_FAST_STEP  = 3'd7;

  // Stick scaling codes; the unused code acts as unity.
  localparam logic [MODE_W-1:0] SCALE_HALF   = 2'd0;
  localparam logic [MODE_W-1:0] SCALE_UNITY  = 2'd1;
  localparam logic [MODE_W-1:0] SCALE_DOUBLE = 2'd2;

  // Reset values.
  localparam logic [MODE_W-1:0] RST_SCALE_MODE = SCALE_HALF;
  localparam logic [POS_W-1:0]  RST_CENTER     = 12'd1500;
  localparam logic [POS_W-1:0]  RST_OUT_MIN    = 12'd1000;
  localparam logic [POS_W-1:0]  RST_OUT_MAX    = 12'd2000;
  localparam logic [POS_W-1:0]  RST_DEAD_LOW   = 12'd1375;
  localparam logic [POS_W-1:0]  RST_DEAD_HIGH  = 12'd1625;
  localparam logic [POS_W-1:0]  RST_SLOW_WIDTH = 12'd125;
  localparam logic [STEP_W-1:0] RST_FAST_STEP  = 8'd2;
  localparam logic [POS_W-1:0]  RST_DRIVE      = 12'd1500;

  localparam logic CMD_STICK    = 1'b0;
  localparam logic CMD_RECENTER = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] scale_mode;
    logic [POS_W-1:0]  center;
    logic [POS_W-1:0]  out_min;
    logic [POS_W-1:0]  out_max;
    logic [POS_W-1:0]  dead_low;
    logic [POS_W-1:0]  dead_high;
    logic [POS_W-1:0]  slow_width;
    logic [STEP_W-1:0] fast_step;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] high_byte;
    logic [BYTE_W-1:0] low_byte;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] drive;
    logic             invalid;
    logic [ERR_W-1:0] err;
  } upd_t;

  typedef enum logic [2:0] {
    BAND_FAST_DOWN,
    BAND_SLOW_DOWN,
    BAND_HOLD,
    BAND_SLOW_UP,
    BAND_FAST_UP
  } band_t;

endpackage

// ----- sv/jrsl_in_if.sv -----
// ----------------------------------------------------------------------------
// jrsl_in_if
// Input channel: command and the two stick bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jrsl_in_if import jrsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] high_byte;
  logic [BYTE_W-1:0] low_byte;

  modport source (output valid, output command, output high_byte, output low_byte,
                  input ready);
  modport sink   (input valid, input command, input high_byte, input low_byte,
                  output ready);
endinterface

// ----- sv/jrsl_out_if.sv -----
// ----------------------------------------------------------------------------
// jrsl_out_if
// Result channel: drive value, invalid flag and error total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jrsl_out_if import jrsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] drive_value;
  logic             invalid;
  logic [ERR_W-1:0] error_total;

  modport source (output valid, output drive_value, output invalid, output error_total,
                  input ready);
  modport sink   (input valid, input drive_value, input invalid, input error_total,
                  output ready);
endinterface

// ----- sv/jrsl_cfg_if.sv -----
// ----------------------------------------------------------------------------
// jrsl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jrsl_cfg_if import jrsl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/jrsl_update.sv -----
// ----------------------------------------------------------------------------
// jrsl_update
// Next drive and error state for one packet: scale, offset, range check,
// band selection and clamped step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jrsl_update import jrsl_pkg::*; (
  input  item_t            item,
  input  cfg_t             cfg,
  input  logic [POS_W-1:0] drive,
  input  logic [ERR_W-1:0] err,
  output upd_t             upd
);

  logic signed [16:0] stick_x;
  logic signed [16:0] scaled;
  logic        [16:0] sum;
  logic        [15:0] cmd;
  logic               in_range;
  logic signed [12:0] cmd_s;
  logic signed [12:0] lo_edge;
  logic        [12:0] hi_edge;
  band_t              band;
  logic [STEP_W-1:0]  step;
  logic [POS_W-1:0]   dn_val;
  logic [POS_W-1:0]   up_val;
  logic [POS_W-1:0]   moved;

  assign stick_x = $signed({item.high_byte[BYTE_W-1], item.high_byte, item.low_byte});

  always_comb begin
    unique case (cfg.scale_mode)
      // Arithmetic shift rounds toward minus infinity; the bias fixes negatives.
      SCALE_HALF:   scaled = (stick_x + $signed({16'd0, stick_x[16]})) >>> 1;
      SCALE_DOUBLE: scaled = stick_x <<< 1;
      default:      scaled = stick_x;
    endcase
  end

  assign sum      = scaled + {5'd0, cfg.center};
  assign cmd      = sum[15:0];
  assign in_range = (cmd >= {4'd0, cfg.out_min}) && (cmd <= {4'd0, cfg.out_max});

  // Inside the valid range the command fits in 12 bits.
  assign cmd_s   = $signed({1'b0, cmd[POS_W-1:0]});
  assign lo_edge = $signed({1'b0, cfg.dead_low}) - $signed({1'b0, cfg.slow_width});
  assign hi_edge = {1'b0, cfg.dead_high} + {1'b0, cfg.slow_width};

  always_comb begin
    priority if (cmd_s < lo_edge) begin
      band = BAND_FAST_DOWN;
    end else if (cmd[POS_W-1:0] < cfg.dead_low) begin
      band = BAND_SLOW_DOWN;
    end else if (cmd[POS_W-1:0] <= cfg.dead_high) begin
      band = BAND_HOLD;
    end else if ({1'b0, cmd[POS_W-1:0]} <= hi_edge) begin
      band = BAND_SLOW_UP;
    end else begin
      band = BAND_FAST_UP;
    end
  end

  assign step = (band == BAND_FAST_DOWN || band == BAND_FAST_UP) ? cfg.fast_step
                                                                 : STEP_W'(1);

  assign dn_val = ({1'b0, drive} > ({1'b0, cfg.out_min} + {5'd0, step}))
                ? (drive - {4'd0, step}) : cfg.out_min;
  assign up_val = ($signed({1'b0, drive}) <
                   ($signed({1'b0, cfg.out_max}) - $signed({5'd0, step})))
                ? (drive + {4'd0, step}) : cfg.out_max;

  always_comb begin
    unique case (band)
      BAND_FAST_DOWN, BAND_SLOW_DOWN: moved = dn_val;
      BAND_SLOW_UP, BAND_FAST_UP:     moved = up_val;
      default:                        moved = drive;
    endcase
  end

  always_comb begin
    upd.drive   = drive;
    upd.invalid = 1'b0;
    upd.err     = err;
    if (item.command == CMD_RECENTER) begin
      upd.drive = cfg.center;
    end else if (!in_range) begin
      upd.invalid = 1'b1;
      upd.err     = err + ERR_W'(1);
    end else begin
      upd.drive = moved;
    end
  end

endmodule

// ----- sv/joystick_rate_slew_limiter_top.sv -----
// Flow: a packet accepted into the input register moves on once the result register is free.
// Throughput: one packet per cycle while out_ch.ready holds; the update logic sits between
// the input register and the result register, and drive and error state update in the same
// cycle. Reset (synchronous, rst_n low): drive 1500, error count 0, registers to defaults.
// ----------------------------------------------------------------------------
// joystick_rate_slew_limiter_top
// Deadband rate limiter for a joystick axis: decodes stick packets, checks
// the command range, counts errors and slews a 12-bit drive value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "joystick_rate_slew_limiter_top_macros.svh"

module joystick_rate_slew_limiter_top import jrsl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  jrsl_in_if.sink           in_ch,
  jrsl_out_if.source        out_ch,
  jrsl_cfg_if.sink          cfg_ch
);

  cfg_t             cfg_r, cfg_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_drive_r;
  logic             out_invalid_r;
  logic [ERR_W-1:0] out_err_r;
  logic [POS_W-1:0] drive_r;
  logic [ERR_W-1:0] err_r;
  logic             s1_adv;
  logic             s1_fire;
  logic             in_fire;
  upd_t             upd;

  // ---------------- configuration registers ----------------
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SCALE_MODE: cfg_nxt.scale_mode = cfg_ch.data[MODE_W-1:0];
        CFG_CENTER:     cfg_nxt.center     = cfg_ch.data[POS_W-1:0];
        CFG_OUT_MIN:    cfg_nxt.out_min    = cfg_ch.data[POS_W-1:0];
        CFG_OUT_MAX:    cfg_nxt.out_max    = cfg_ch.data[POS_W-1:0];
        CFG_DEAD_LOW:   cfg_nxt.dead_low   = cfg_ch.data[POS_W-1:0];
        CFG_DEAD_HIGH:  cfg_nxt.dead_high  = cfg_ch.data[POS_W-1:0];
        CFG_SLOW_WIDTH: cfg_nxt.slow_width = cfg_ch.data[POS_W-1:0];
        CFG_FAST_STEP:  cfg_nxt.fast_step  = cfg_ch.data[STEP_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_mode <= RST_SCALE_MODE;
      cfg_r.center     <= RST_CENTER;
      cfg_r.out_min    <= RST_OUT_MIN;
      cfg_r.out_max    <= RST_OUT_MAX;
      cfg_r.dead_low   <= RST_DEAD_LOW;
      cfg_r.dead_high  <= RST_DEAD_HIGH;
      cfg_r.slow_width <= RST_SLOW_WIDTH;
      cfg_r.fast_step  <= RST_FAST_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- input register ----------------
  // The input stage moves on whenever the result register is empty or drains.
  assign s1_adv       = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && s1_adv;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.command   <= in_ch.command;
      s1_item_r.high_byte <= in_ch.high_byte;
      s1_item_r.low_byte  <= in_ch.low_byte;
    end
  end

  // ---------------- update and result register ----------------
  jrsl_update u_update (
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .drive (drive_r),
    .err   (err_r),
    .upd   (upd)
  );

  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      drive_r     <= RST_DRIVE;
      err_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        drive_r <= upd.drive;
        err_r   <= upd.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_drive_r   <= upd.drive;
      out_invalid_r <= upd.invalid;
      out_err_r     <= upd.err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = out_drive_r;
  assign out_ch.invalid     = out_invalid_r;
  assign out_ch.error_total = out_err_r;

  // ---------------- assertions ----------------
  `JRSL_ASSERT_NXT(a_drive_holds_when_idle, !s1_fire, $stable(drive_r), "drive changed without a packet")
  `JRSL_ASSERT_NXT(a_err_only_on_invalid, s1_fire && !upd.invalid, $stable(err_r), "error count moved on a valid beat")
  `JRSL_ASSERT_IMP(a_out_drive_tracks_state, out_valid_r, out_drive_r == drive_r, "result drive differs from state")
  `JRSL_ASSERT_IMP(a_out_err_tracks_state, out_valid_r, out_err_r == err_r, "result error total differs from state")
  `JRSL_ASSERT_IMP(a_recenter_valid, s1_fire && s1_item_r.command == CMD_RECENTER, !upd.invalid, "re-center flagged invalid")

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the joystick rate slew limiter. A local predictor
// follows every register write and every accepted packet and queues the
// expected drive update. Each result beat is compared field by field. Packets
// go in bursts with random gaps and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import jrsl_pkg::*;

  // Scale code that has no name in the package; the block treats it as unity.
  localparam logic [MODE_W-1:0] SCALE_SPARE = 2'd3;

  logic clk;
  logic rst_n;

  jrsl_in_if  in_ch ();
  jrsl_out_if out_ch ();
  jrsl_cfg_if cfg_ch ();

  joystick_rate_slew_limiter_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: register mirror, drive position and error counter.
  cfg_t             lim_cfg;
  logic [POS_W-1:0] drive_q;
  logic [ERR_W-1:0] err_q;
  upd_t             pending_updates[$];
  int               mismatch_count = 0;
  int               burst_left = 8;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic cfg_t reset_settings();
    cfg_t st;
    st.scale_mode = RST_SCALE_MODE;
    st.center     = RST_CENTER;
    st.out_min    = RST_OUT_MIN;
    st.out_max    = RST_OUT_MAX;
    st.dead_low   = RST_DEAD_LOW;
    st.dead_high  = RST_DEAD_HIGH;
    st.slow_width = RST_SLOW_WIDTH;
    st.fast_step  = RST_FAST_STEP;
    return st;
  endfunction

  function automatic logic [POS_W-1:0] slew_down(int pos, int amount);
    if (pos > int'(lim_cfg.out_min) + amount) return POS_W'(pos - amount);
    return lim_cfg.out_min;
  endfunction

  function automatic logic [POS_W-1:0] slew_up(int pos, int amount);
    if (pos < int'(lim_cfg.out_max) - amount) return POS_W'(pos + amount);
    return lim_cfg.out_max;
  endfunction

  // Applies one packet to the predicted axis state and returns the update.
  function automatic upd_t advance_axis(item_t pkt);
    upd_t        upd;
    logic [15:0] raw;
    int          stick;
    int          scaled;
    int          cmd_pos;
    band_t       band;
    upd.invalid = 1'b0;
    if (pkt.command == CMD_RECENTER) begin
      drive_q = lim_cfg.center;
    end else begin
      raw   = {pkt.high_byte, pkt.low_byte};
      stick = int'($signed(raw));
      case (lim_cfg.scale_mode)
        SCALE_HALF:   scaled = stick / 2;
        SCALE_DOUBLE: scaled = stick * 2;
        default:      scaled = stick;
      endcase
      cmd_pos = (scaled + int'(lim_cfg.center)) & 32'hFFFF;
      if (cmd_pos < int'(lim_cfg.out_min) || cmd_pos > int'(lim_cfg.out_max)) begin
        upd.invalid = 1'b1;
        err_q       = err_q + 1'b1;
      end else begin
        if (cmd_pos < int'(lim_cfg.dead_low) - int'(lim_cfg.slow_width))
          band = BAND_FAST_DOWN;
        else if (cmd_pos < int'(lim_cfg.dead_low))
          band = BAND_SLOW_DOWN;
        else if (cmd_pos <= int'(lim_cfg.dead_high))
          band = BAND_HOLD;
        else if (cmd_pos <= int'(lim_cfg.dead_high) + int'(lim_cfg.slow_width))
          band = BAND_SLOW_UP;
        else
          band = BAND_FAST_UP;
        case (band)
          BAND_FAST_DOWN: drive_q = slew_down(drive_q, lim_cfg.fast_step);
          BAND_SLOW_DOWN: drive_q = slew_down(drive_q, 1);
          BAND_SLOW_UP:   drive_q = slew_up(drive_q, 1);
          BAND_FAST_UP:   drive_q = slew_up(drive_q, lim_cfg.fast_step);
          default:        drive_q = drive_q;
        endcase
      end
    end
    upd.drive = drive_q;
    upd.err   = err_q;
    return upd;
  endfunction

  // Watches all three channels at each edge: checks result beats, follows
  // register writes and predicts the update for each accepted packet.
  always @(posedge clk) begin
    upd_t  want;
    item_t pkt;
    if (!rst_n) begin
      lim_cfg = reset_settings();
      drive_q = RST_DRIVE;
      err_q   = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_updates.size() == 0) begin
          $display("%0t unexpected result beat: drive_value %0d invalid %0b error_total %0d",
                   $time, out_ch.drive_value, out_ch.invalid, out_ch.error_total);
          mismatch_count++;
        end else begin
          want = pending_updates.pop_front();
          if (out_ch.drive_value !== want.drive) begin
            $display("%0t drive_value mismatch: expected %0d actual %0d",
                     $time, want.drive, out_ch.drive_value);
            mismatch_count++;
          end
          if (out_ch.invalid !== want.invalid) begin
            $display("%0t invalid mismatch: expected %0b actual %0b",
                     $time, want.invalid, out_ch.invalid);
            mismatch_count++;
          end
          if (out_ch.error_total !== want.err) begin
            $display("%0t error_total mismatch: expected %0d actual %0d",
                     $time, want.err, out_ch.error_total);
            mismatch_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_SCALE_MODE: lim_cfg.scale_mode = cfg_ch.data[MODE_W-1:0];
          CFG_CENTER:     lim_cfg.center     = cfg_ch.data;
          CFG_OUT_MIN:    lim_cfg.out_min    = cfg_ch.data;
          CFG_OUT_MAX:    lim_cfg.out_max    = cfg_ch.data;
          CFG_DEAD_LOW:   lim_cfg.dead_low   = cfg_ch.data;
          CFG_DEAD_HIGH:  lim_cfg.dead_high  = cfg_ch.data;
          CFG_SLOW_WIDTH: lim_cfg.slow_width = cfg_ch.data;
          CFG_FAST_STEP:  lim_cfg.fast_step  = cfg_ch.data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        pkt = {in_ch.command, in_ch.high_byte, in_ch.low_byte};
        pending_updates.push_back(advance_axis(pkt));
      end
    end
  end

  // Result side: ready follows a style that is redrawn after each random span.
  initial begin
    int stall_style;
    int span;
    int tick;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      stall_style = $urandom_range(0, 3);
      span        = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (stall_style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((tick % 6) < 3);
        endcase
      end
    end
  end

  // Sends one packet and waits for its beat. Valid stays high inside a burst;
  // at the end of a burst the sender may go quiet for a random gap.
  task automatic push_packet(item_t pkt);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.command   <= pkt.command;
    in_ch.high_byte <= pkt.high_byte;
    in_ch.low_byte  <= pkt.low_byte;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops sending and waits until every predicted update has come back.
  task automatic drain_updates();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all eight registers. Unused upper data bits of the narrow
  // registers are sometimes filled with noise, which the block must drop.
  task automatic apply_settings(cfg_t st);
    logic [CDATA_W-1:0] wdata[1 << CIDX_W];
    logic [CDATA_W-1:0] noise;
    noise = ($urandom_range(0, 1) == 1) ? CDATA_W'($urandom) : '0;
    wdata[CFG_SCALE_MODE] = {noise[CDATA_W-1:MODE_W], st.scale_mode};
    wdata[CFG_CENTER]     = st.center;
    wdata[CFG_OUT_MIN]    = st.out_min;
    wdata[CFG_OUT_MAX]    = st.out_max;
    wdata[CFG_DEAD_LOW]   = st.dead_low;
    wdata[CFG_DEAD_HIGH]  = st.dead_high;
    wdata[CFG_SLOW_WIDTH] = st.slow_width;
    wdata[CFG_FAST_STEP]  = {noise[CDATA_W-1:STEP_W], st.fast_step};
    for (int i = 0; i < (1 << CIDX_W); i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CIDX_W'(i);
      cfg_ch.data  <= wdata[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Builds a stick packet whose decoded command lands on pos under the
  // current scale and center.
  function automatic item_t stick_toward(int pos);
    int          delta;
    int          stick;
    logic [15:0] raw;
    delta = pos - int'(lim_cfg.center);
    case (lim_cfg.scale_mode)
      SCALE_HALF:   stick = delta * 2;
      SCALE_DOUBLE: stick = delta / 2;
      default:      stick = delta;
    endcase
    raw = 16'(stick);
    return {CMD_STICK, raw[15:8], raw[7:0]};
  endfunction

  function automatic item_t random_packet();
    item_t pkt;
    int    pick;
    int    anchor;
    int    lo;
    int    hi;
    pick = $urandom_range(0, 99);
    pkt  = {CMD_STICK, BYTE_W'($urandom), BYTE_W'($urandom)};
    if (pick < 12) begin
      pkt.command = CMD_RECENTER;
    end else if (pick >= 30) begin
      lo = (lim_cfg.out_min < lim_cfg.out_max) ? lim_cfg.out_min : lim_cfg.out_max;
      hi = (lim_cfg.out_min < lim_cfg.out_max) ? lim_cfg.out_max : lim_cfg.out_min;
      case ($urandom_range(0, 6))
        0:       anchor = lim_cfg.out_min;
        1:       anchor = lim_cfg.out_max;
        2:       anchor = lim_cfg.dead_low;
        3:       anchor = lim_cfg.dead_high;
        4:       anchor = int'(lim_cfg.dead_low) - int'(lim_cfg.slow_width);
        5:       anchor = int'(lim_cfg.dead_high) + int'(lim_cfg.slow_width);
        default: anchor = $urandom_range(lo, hi);
      endcase
      pkt = stick_toward(anchor + $urandom_range(0, 6) - 3);
    end
    return pkt;
  endfunction

  function automatic cfg_t pick_settings(int flavor);
    cfg_t st;
    int   lo;
    int   hi;
    int   dl;
    st.scale_mode = MODE_W'($urandom_range(0, 3));
    case (flavor)
      0: begin
        lo = $urandom_range(0, 2000);
        hi = lo + $urandom_range(100, 2000);
        if (hi > 4095) hi = 4095;
        dl = $urandom_range(lo, hi);
        st.out_min    = POS_W'(lo);
        st.out_max    = POS_W'(hi);
        st.center     = POS_W'($urandom_range(lo, hi));
        st.dead_low   = POS_W'(dl);
        st.dead_high  = POS_W'((dl + $urandom_range(0, 400) > 4095) ? 4095
                                                                     : dl + $urandom_range(0, 400));
        st.slow_width = POS_W'($urandom_range(0, 300));
        st.fast_step  = STEP_W'($urandom_range(0, 40));
      end
      1: begin
        st.out_min    = '0;
        st.out_max    = '1;
        st.center     = ($urandom_range(0, 1) == 1) ? '1 : '0;
        st.dead_low   = POS_W'($urandom);
        st.dead_high  = POS_W'($urandom);
        st.slow_width = ($urandom_range(0, 1) == 1) ? '1 : '0;
        st.fast_step  = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      default: begin
        st.center     = POS_W'($urandom);
        st.out_min    = POS_W'($urandom);
        st.out_max    = POS_W'($urandom);
        st.dead_low   = POS_W'($urandom);
        st.dead_high  = POS_W'($urandom);
        st.slow_width = POS_W'($urandom);
        st.fast_step  = STEP_W'($urandom);
      end
    endcase
    return st;
  endfunction

  // Registers at their reset values, halving scale: byte extremes and a
  // re-center.
  task automatic test_reset_defaults();
    push_packet({CMD_RECENTER, 8'hFF, 8'hFF});
    push_packet({CMD_STICK, 8'h7F, 8'hFF});
    push_packet({CMD_STICK, 8'h80, 8'h00});
    push_packet({CMD_STICK, 8'hFF, 8'hFF});
    push_packet({CMD_STICK, 8'h00, 8'h01});
    push_packet({CMD_STICK, 8'h02, 8'h00});
  endtask

  // Unity scale: one packet on each side of every band edge and range limit.
  task automatic test_band_edges();
    cfg_t st;
    int   edges[12] = '{999, 1000, 1249, 1250, 1374, 1375,
                        1625, 1626, 1750, 1751, 2000, 2001};
    st            = reset_settings();
    st.scale_mode = SCALE_UNITY;
    drain_updates();
    apply_settings(st);
    foreach (edges[i]) push_packet(stick_toward(edges[i]));
  endtask

  // Doubling wraps the extreme sticks around modulo 65536; the spare code
  // must behave as unity.
  task automatic test_scale_modes();
    cfg_t st;
    st            = reset_settings();
    st.scale_mode = SCALE_DOUBLE;
    drain_updates();
    apply_settings(st);
    push_packet({CMD_STICK, 8'h7F, 8'hFF});
    push_packet({CMD_STICK, 8'h80, 8'h00});
    st.scale_mode = SCALE_SPARE;
    drain_updates();
    apply_settings(st);
    push_packet({CMD_STICK, 8'h01, 8'h00});
  endtask

  // A re-center outside the limits leaves the drive out of range; the next
  // step toward a limit must pull it onto that limit.
  task automatic test_limit_pull();
    cfg_t st;
    st            = reset_settings();
    st.scale_mode = SCALE_UNITY;
    st.center     = 12'd3000;
    drain_updates();
    apply_settings(st);
    push_packet({CMD_RECENTER, 8'h00, 8'h00});
    push_packet(stick_toward(1800));
    st.center = 12'd500;
    drain_updates();
    apply_settings(st);
    push_packet({CMD_RECENTER, 8'h00, 8'h00});
    push_packet(stick_toward(1100));
  endtask

  // With an empty valid range every stick packet is an error, which walks
  // the error counter through its wrap.
  task automatic test_error_wrap();
    cfg_t  st;
    item_t pkt;
    st         = reset_settings();
    st.out_min = '1;
    st.out_max = '0;
    drain_updates();
    apply_settings(st);
    repeat (270) begin
      pkt = {CMD_STICK, BYTE_W'($urandom), BYTE_W'($urandom)};
      if ($urandom_range(0, 19) == 0) pkt.command = CMD_RECENTER;
      push_packet(pkt);
    end
  endtask

  task automatic test_random_traffic();
    cfg_t st;
    for (int phase = 0; phase < 12; phase++) begin
      st = pick_settings(phase % 3);
      drain_updates();
      apply_settings(st);
      for (int k = 0; k < 30; k++) begin
        // Once in the run the sender waits for the pipe to empty mid-phase.
        if (phase == 4 && k == 15) drain_updates();
        push_packet(random_packet());
      end
    end
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_STICK;
    in_ch.high_byte <= '0;
    in_ch.low_byte  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_SCALE_MODE;
    cfg_ch.data     <= '0;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_band_edges();
    test_scale_modes();
    test_limit_pull();
    test_error_wrap();
    test_random_traffic();

    drain_updates();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/jrsl_pkg.sv
sv/jrsl_in_if.sv
sv/jrsl_out_if.sv
sv/jrsl_cfg_if.sv
sv/jrsl_update.sv
sv/joystick_rate_slew_limiter_top.sv
test/tb_top.sv
